// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ===== rtl/tcpo_pkg.sv =====
`timescale 1ns / 1ps

package tcpo_pkg;

   typedef enum logic [1:0] {
      PH_KIND,
      PH_LEN,
      PH_BODY,
      PH_STOP
   } phase_type;

   localparam logic [7:0] KIND_END   = 8'd0;
   localparam logic [7:0] KIND_NOP   = 8'd1;
   localparam logic [7:0] KIND_MSS   = 8'd2;
   localparam logic [7:0] KIND_SCALE = 8'd3;

   // smallest legal option length (kind + length bytes)
   localparam logic [7:0] MIN_LEN = 8'd2;

   // position inside an option body, saturating at IDX_PAST
   localparam logic [1:0] IDX_HIGH = 2'd0;
   localparam logic [1:0] IDX_LOW  = 2'd1;
   localparam logic [1:0] IDX_PAST = 2'd2;

   typedef struct packed {
      logic [15:0] mss;
      logic        mss_found;
      logic [7:0]  window_scale;
      logic        scale_found;
      logic        malformed;
   } result_type;

endpackage

// ===== rtl/tcpo_walker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tcpo_walker
   import tcpo_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       adv,
   input  logic [7:0] opt_byte,
   input  logic       last,
   output result_type result
);

   phase_type   phase_ff, phase_in, phase_nx;
   logic        kind_mss_ff, kind_mss_in, kind_mss_nx;
   logic        kind_scale_ff, kind_scale_in, kind_scale_nx;
   logic [7:0]  bytes_left_ff, bytes_left_in, bytes_left_nx;
   logic [1:0]  value_index_ff, value_index_in, value_index_nx;
   logic [7:0]  mss_high_ff, mss_high_in, mss_high_nx;
   logic [15:0] mss_value_ff, mss_value_in, mss_value_nx;
   logic        mss_seen_ff, mss_seen_in, mss_seen_nx;
   logic [7:0]  scale_value_ff, scale_value_in, scale_value_nx;
   logic        scale_seen_ff, scale_seen_in, scale_seen_nx;
   logic        bad_length_ff, bad_length_in, bad_length_nx;

   always_comb begin
      phase_nx       = phase_ff;
      kind_mss_nx    = kind_mss_ff;
      kind_scale_nx  = kind_scale_ff;
      bytes_left_nx  = bytes_left_ff;
      value_index_nx = value_index_ff;
      mss_high_nx    = mss_high_ff;
      mss_value_nx   = mss_value_ff;
      mss_seen_nx    = mss_seen_ff;
      scale_value_nx = scale_value_ff;
      scale_seen_nx  = scale_seen_ff;
      bad_length_nx  = bad_length_ff;
      case (phase_ff)
         PH_KIND: begin
            if (opt_byte == KIND_END) begin
               phase_nx = PH_STOP;
            end else if (opt_byte != KIND_NOP) begin
               kind_mss_nx   = (opt_byte == KIND_MSS);
               kind_scale_nx = (opt_byte == KIND_SCALE);
               phase_nx      = PH_LEN;
            end
         end
         PH_LEN: begin
            if (opt_byte < MIN_LEN) begin
               bad_length_nx = 1'b1;
               phase_nx      = PH_STOP;
            end else if (opt_byte == MIN_LEN) begin
               phase_nx = PH_KIND;
            end else begin
               bytes_left_nx  = opt_byte - MIN_LEN;
               value_index_nx = IDX_HIGH;
               phase_nx       = PH_BODY;
            end
         end
         PH_BODY: begin
            if (kind_mss_ff) begin
               if (value_index_ff == IDX_HIGH) begin
                  mss_high_nx = opt_byte;
               end else if (value_index_ff == IDX_LOW) begin
                  mss_value_nx = {mss_high_ff, opt_byte};
                  mss_seen_nx  = 1'b1;
               end
            end else if (kind_scale_ff && value_index_ff == IDX_HIGH) begin
               scale_value_nx = opt_byte;
               scale_seen_nx  = 1'b1;
            end
            if (value_index_ff != IDX_PAST) begin
               value_index_nx = value_index_ff + 2'd1;
            end
            bytes_left_nx = bytes_left_ff - 8'd1;
            if (bytes_left_ff == 8'd1) begin
               phase_nx = PH_KIND;
            end
         end
         default: begin
            // end of list or bad length: ignore the rest of the area
         end
      endcase
   end

   assign result.mss          = mss_seen_nx ? mss_value_nx : 16'd0;
   assign result.mss_found    = mss_seen_nx;
   assign result.window_scale = scale_seen_nx ? scale_value_nx : 8'd0;
   assign result.scale_found  = scale_seen_nx;
   assign result.malformed    = bad_length_nx;

   always_comb begin
      phase_in       = phase_ff;
      kind_mss_in    = kind_mss_ff;
      kind_scale_in  = kind_scale_ff;
      bytes_left_in  = bytes_left_ff;
      value_index_in = value_index_ff;
      mss_high_in    = mss_high_ff;
      mss_value_in   = mss_value_ff;
      mss_seen_in    = mss_seen_ff;
      scale_value_in = scale_value_ff;
      scale_seen_in  = scale_seen_ff;
      bad_length_in  = bad_length_ff;
      if (adv && last) begin
         // segment done: clear for the next option area
         phase_in       = PH_KIND;
         kind_mss_in    = 1'b0;
         kind_scale_in  = 1'b0;
         bytes_left_in  = 8'd0;
         value_index_in = IDX_HIGH;
         mss_high_in    = 8'd0;
         mss_value_in   = 16'd0;
         mss_seen_in    = 1'b0;
         scale_value_in = 8'd0;
         scale_seen_in  = 1'b0;
         bad_length_in  = 1'b0;
      end else if (adv) begin
         phase_in       = phase_nx;
         kind_mss_in    = kind_mss_nx;
         kind_scale_in  = kind_scale_nx;
         bytes_left_in  = bytes_left_nx;
         value_index_in = value_index_nx;
         mss_high_in    = mss_high_nx;
         mss_value_in   = mss_value_nx;
         mss_seen_in    = mss_seen_nx;
         scale_value_in = scale_value_nx;
         scale_seen_in  = scale_seen_nx;
         bad_length_in  = bad_length_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_KIND;
         kind_mss_ff    <= 1'b0;
         kind_scale_ff  <= 1'b0;
         bytes_left_ff  <= 8'd0;
         value_index_ff <= IDX_HIGH;
         mss_high_ff    <= 8'd0;
         mss_value_ff   <= 16'd0;
         mss_seen_ff    <= 1'b0;
         scale_value_ff <= 8'd0;
         scale_seen_ff  <= 1'b0;
         bad_length_ff  <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         kind_mss_ff    <= kind_mss_in;
         kind_scale_ff  <= kind_scale_in;
         bytes_left_ff  <= bytes_left_in;
         value_index_ff <= value_index_in;
         mss_high_ff    <= mss_high_in;
         mss_value_ff   <= mss_value_in;
         mss_seen_ff    <= mss_seen_in;
         scale_value_ff <= scale_value_in;
         scale_seen_ff  <= scale_seen_in;
         bad_length_ff  <= bad_length_in;
      end
   end

   `ASSERT_IMPLY(a_body_has_bytes, clock, reset, phase_ff == PH_BODY, bytes_left_ff != 8'd0)
   `ASSERT_NEXT(a_clear_after_last, clock, reset, adv && last,
                phase_ff == PH_KIND && !mss_seen_ff && !scale_seen_ff && !bad_length_ff)
   `ASSERT_IMPLY(a_kind_exclusive, clock, reset, kind_mss_ff, !kind_scale_ff)

endmodule

// ===== rtl/tcpo_rsp_reg.sv =====
`timescale 1ns / 1ps

module tcpo_rsp_reg
   import tcpo_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  result_type  result,
   output logic        ready,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_mss,
   output logic        rsp_mss_found,
   output logic [7:0]  rsp_window_scale,
   output logic        rsp_scale_found,
   output logic        rsp_malformed
);

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   // slot frees when empty or when the held result transfers this cycle
   assign ready = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = result;
      end else if (ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_mss          = data_ff.mss;
   assign rsp_mss_found    = data_ff.mss_found;
   assign rsp_window_scale = data_ff.window_scale;
   assign rsp_scale_found  = data_ff.scale_found;
   assign rsp_malformed    = data_ff.malformed;

endmodule

// ===== rtl/tcp_option_parser.sv =====
// TCP option parser: MSS and window scale from a byte stream of the option area.
// Only a last byte yields a result: byte in s1, then result in the response register.
// Throughput: one byte per cycle, one walker update per byte, unless a last byte waits.
// An input skid register keeps req_stall registered; it asserts only under result stall.
// Reset (synchronous, active high) empties all stages and clears the parse state.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tcp_option_parser
   import tcpo_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_opt_byte,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_mss,
   output logic        rsp_mss_found,
   output logic [7:0]  rsp_window_scale,
   output logic        rsp_scale_found,
   output logic        rsp_malformed
);

   logic       skid_valid_ff, skid_valid_in;
   logic [7:0] skid_byte_ff, skid_byte_in;
   logic       skid_last_ff, skid_last_in;
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff, s1_byte_in;
   logic       s1_last_ff, s1_last_in;

   logic       req_xfer;
   logic       out_ready;
   logic       s1_adv;
   logic       s1_free;
   result_type result;

   assign req_stall = skid_valid_ff;
   assign req_xfer  = req_valid && !req_stall;

   // bytes without last produce nothing and never wait on the result side
   assign s1_adv  = s1_valid_ff && (out_ready || !s1_last_ff);
   assign s1_free = !s1_valid_ff || s1_adv;

   always_comb begin
      skid_valid_in = skid_valid_ff;
      skid_byte_in  = skid_byte_ff;
      skid_last_in  = skid_last_ff;
      s1_valid_in   = s1_valid_ff;
      s1_byte_in    = s1_byte_ff;
      s1_last_in    = s1_last_ff;
      if (s1_free) begin
         if (skid_valid_ff) begin
            s1_valid_in   = 1'b1;
            s1_byte_in    = skid_byte_ff;
            s1_last_in    = skid_last_ff;
            skid_valid_in = 1'b0;
         end else begin
            s1_valid_in = req_xfer;
            s1_byte_in  = req_opt_byte;
            s1_last_in  = req_last;
         end
      end else if (req_xfer) begin
         skid_valid_in = 1'b1;
         skid_byte_in  = req_opt_byte;
         skid_last_in  = req_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
         s1_valid_ff   <= 1'b0;
      end else begin
         skid_valid_ff <= skid_valid_in;
         s1_valid_ff   <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      skid_byte_ff <= skid_byte_in;
      skid_last_ff <= skid_last_in;
      s1_byte_ff   <= s1_byte_in;
      s1_last_ff   <= s1_last_in;
   end

   tcpo_walker u_walker (
      .clock    (clock),
      .reset    (reset),
      .adv      (s1_adv),
      .opt_byte (s1_byte_ff),
      .last     (s1_last_ff),
      .result   (result)
   );

   tcpo_rsp_reg u_rsp_reg (
      .clock            (clock),
      .reset            (reset),
      .load             (s1_adv && s1_last_ff),
      .result           (result),
      .ready            (out_ready),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_mss          (rsp_mss),
      .rsp_mss_found    (rsp_mss_found),
      .rsp_window_scale (rsp_window_scale),
      .rsp_scale_found  (rsp_scale_found),
      .rsp_malformed    (rsp_malformed)
   );

   `ASSERT_IMPLY(a_skid_behind_s1, clock, reset, skid_valid_ff, s1_valid_ff)
   `ASSERT_NEXT(a_last_reaches_rsp, clock, reset, s1_adv && s1_last_ff, rsp_valid)

endmodule
